// ===== rtl/core/assert_macros.svh =====
// assertion macros for the rtl file that checks its own logic, the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/mbaf_pkg.sv =====
// types and constants of the masked box average filter
`timescale 1ns / 1ps

package mbaf_pkg;

	localparam int PIX_W     = 8;
	localparam int ROW_W     = 11;
	localparam int OUT_COL_W = 11;
	localparam int AVG_W     = 16;
	localparam int JOB_DEPTH = 4;

	localparam logic [11:0] MAX_ROWS     = 12'd2048;
	localparam logic [3:0]  RADIUS_RESET = 4'd2;
	localparam logic [11:0] WIDTH_RESET  = 12'd2048;
	localparam logic [11:0] HEIGHT_RESET = 12'd2048;

	typedef enum logic [1:0] {
		REG_RADIUS       = 2'd0,
		REG_FRAME_WIDTH  = 2'd1,
		REG_FRAME_HEIGHT = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             pixel_ok;
		logic             frame_start;
	} in_beat_t;

	typedef struct packed {
		logic [AVG_W-1:0]     average;
		logic [OUT_COL_W-1:0] centre_column;
		logic [ROW_W-1:0]     centre_row;
	} out_beat_t;

	typedef struct packed {
		logic [3:0]  radius;
		logic [11:0] frame_width;
		logic [11:0] frame_height;
	} cfg_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_SUM,
		F_WRITE
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_READ,
		B_DRAIN,
		B_LOAD,
		B_DIV,
		B_OUT
	} back_state_t;

endpackage

// ===== rtl/core/mbaf_fifo.sv =====
// short job queue between the front and the back of the filter
`timescale 1ns / 1ps

module mbaf_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] data_in,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] data_out,
	output logic         empty
);

	localparam int P_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int C_W = $clog2(DEPTH + 1);

	logic [W-1:0]   slots_q [DEPTH];
	logic [P_W-1:0] wr_ptr_q;
	logic [P_W-1:0] rd_ptr_q;
	logic [C_W-1:0] count_q;
	logic           do_push;
	logic           do_pop;

	// handshake qualifiers
	assign full     = (count_q == C_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign data_out = slots_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == P_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == P_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= data_in;
		end
	end

endmodule

// ===== rtl/core/mbaf_front.sv =====
// front: accepts pixels, tracks position, forms horizontal window sums
`timescale 1ns / 1ps

module mbaf_front import mbaf_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_RADIUS = 15,
	localparam int RING   = 2 * MAX_RADIUS + 1,
	localparam int SLOT_W = $clog2(RING),
	localparam int COL_W  = $clog2(MAX_WIDTH),
	localparam int R_W    = $clog2(MAX_RADIUS + 1),
	localparam int HS_W   = $clog2(RING * 255 + 1),
	localparam int HC_W   = $clog2(RING + 1),
	localparam int E_W    = HS_W + HC_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  in_beat_t          item,
	input  cfg_t              cfg,
	output logic              wr_en,
	output logic [SLOT_W-1:0] wr_slot,
	output logic [COL_W-1:0]  wr_col,
	output logic [E_W-1:0]    wr_data,
	output logic              job_push,
	input  logic              job_full,
	input  logic              job_empty,
	input  logic              back_reading,
	output logic [COL_W-1:0]  job_col,
	output logic [ROW_W-1:0]  job_row,
	output logic [SLOT_W-1:0] job_slot,
	output logic [R_W-1:0]    job_r,
	output logic              job_clr
);

	localparam int GROUPS = (RING + 7) / 8;
	localparam int WW     = $clog2(MAX_WIDTH + 1);

	front_state_t      state_q, state_d;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SLOT_W-1:0] slot_q;
	logic              clr_pend_q;
	logic [8:0]        taps_q [RING];

	logic [COL_W-1:0]  col_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [R_W-1:0]    r_s1;
	logic              wr_ok_s1;
	logic              job_ok_s1;
	logic [HS_W-1:0]   psum_s2 [GROUPS];
	logic [HC_W-1:0]   pcnt_s2 [GROUPS];

	logic [R_W-1:0]    r;
	logic [WW-1:0]     w;
	logic [11:0]       h;
	logic              accept;
	logic [COL_W-1:0]  col_cur, col_nx;
	logic [ROW_W-1:0]  row_cur, row_nx;
	logic [SLOT_W-1:0] slot_cur, slot_nx;
	logic              wr_ok, job_ok;
	logic [HS_W-1:0]   psum_d [GROUPS];
	logic [HC_W-1:0]   pcnt_d [GROUPS];
	logic [HS_W-1:0]   hs;
	logic [HC_W-1:0]   hc;
	logic              store_free;
	logic              leave_write;

	// effective geometry
	always_comb begin
		if (32'(cfg.radius) > MAX_RADIUS) begin
			r = R_W'(MAX_RADIUS);
		end else begin
			r = R_W'(cfg.radius);
		end
		if (cfg.frame_width == '0) begin
			w = WW'(1);
		end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
			w = WW'(MAX_WIDTH);
		end else begin
			w = WW'(cfg.frame_width);
		end
		if (cfg.frame_height == '0) begin
			h = 12'd1;
		end else if (cfg.frame_height > MAX_ROWS) begin
			h = MAX_ROWS;
		end else begin
			h = cfg.frame_height;
		end
	end

	// position of the incoming pixel and of the next one
	always_comb begin
		accept   = push && (state_q == F_IDLE);
		col_cur  = item.frame_start ? '0 : col_q;
		row_cur  = item.frame_start ? '0 : row_q;
		slot_cur = item.frame_start ? '0 : slot_q;
		wr_ok    = (32'(col_cur) >= 2 * 32'(r)) && (32'(col_cur) < 32'(w));
		job_ok   = wr_ok && (32'(row_cur) >= 2 * 32'(r)) && (32'(row_cur) < 32'(h));
		col_nx   = col_cur;
		row_nx   = row_cur;
		slot_nx  = slot_cur;
		if (32'(col_cur) + 1 >= 32'(w)) begin
			col_nx = '0;
			if (32'(row_cur) + 1 >= 32'(h)) begin
				row_nx  = '0;
				slot_nx = '0;
			end else begin
				row_nx  = row_cur + 1'b1;
				slot_nx = (slot_cur == SLOT_W'(RING - 1)) ? '0 : slot_cur + 1'b1;
			end
		end else begin
			col_nx = col_cur + 1'b1;
		end
	end

	// partial window sums in groups of eight taps
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			psum_d[g] = '0;
			pcnt_d[g] = '0;
		end
		for (int k = 0; k < RING; k++) begin
			if (k <= 2 * int'(r_s1)) begin
				psum_d[k >> 3] = psum_d[k >> 3] + HS_W'(taps_q[k][7:0]);
				pcnt_d[k >> 3] = pcnt_d[k >> 3] + HC_W'(taps_q[k][8]);
			end
		end
	end

	// final horizontal sum
	always_comb begin
		hs = '0;
		hc = '0;
		for (int g = 0; g < GROUPS; g++) begin
			hs = hs + psum_s2[g];
			hc = hc + pcnt_s2[g];
		end
	end

	// sequencer; a store write waits until no queued or active job can still read the store
	always_comb begin
		state_d     = state_q;
		store_free  = job_empty && !back_reading;
		leave_write = (!job_ok_s1 || !job_full) && (!wr_ok_s1 || store_free);
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_d = F_SUM;
				end
			end
			F_SUM: begin
				state_d = F_WRITE;
			end
			F_WRITE: begin
				if (leave_write) begin
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	assign full     = (state_q != F_IDLE);
	assign wr_en    = (state_q == F_WRITE) && wr_ok_s1 && leave_write;
	assign wr_slot  = slot_s1;
	assign wr_col   = col_s1;
	assign wr_data  = {hs, hc};
	assign job_push = (state_q == F_WRITE) && job_ok_s1 && leave_write;
	assign job_col  = col_s1;
	assign job_row  = row_s1;
	assign job_slot = slot_s1;
	assign job_r    = r_s1;
	assign job_clr  = clr_pend_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			col_q      <= '0;
			row_q      <= '0;
			slot_q     <= '0;
			clr_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				col_q  <= col_nx;
				row_q  <= row_nx;
				slot_q <= slot_nx;
			end
			if (accept && item.frame_start) begin
				clr_pend_q <= 1'b1;
			end else if (job_push) begin
				clr_pend_q <= 1'b0;
			end
		end
	end

	// pixel line and per-pixel stage registers
	always_ff @(posedge clk) begin
		if (accept) begin
			taps_q[0] <= {item.pixel_ok, item.pixel_ok ? item.pixel : {PIX_W{1'b0}}};
			for (int k = 1; k < RING; k++) begin
				taps_q[k] <= taps_q[k-1];
			end
			col_s1    <= col_cur;
			row_s1    <= row_cur;
			slot_s1   <= slot_cur;
			r_s1      <= r;
			wr_ok_s1  <= wr_ok;
			job_ok_s1 <= job_ok;
		end
		if (state_q == F_SUM) begin
			for (int g = 0; g < GROUPS; g++) begin
				psum_s2[g] <= psum_d[g];
				pcnt_s2[g] <= pcnt_d[g];
			end
		end
	end

endmodule

// ===== rtl/core/mbaf_back.sv =====
// back: row sum store, vertical accumulation, divider and result register
`timescale 1ns / 1ps

module mbaf_back import mbaf_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_RADIUS = 15,
	localparam int RING   = 2 * MAX_RADIUS + 1,
	localparam int SLOT_W = $clog2(RING),
	localparam int COL_W  = $clog2(MAX_WIDTH),
	localparam int R_W    = $clog2(MAX_RADIUS + 1),
	localparam int HS_W   = $clog2(RING * 255 + 1),
	localparam int HC_W   = $clog2(RING + 1),
	localparam int E_W    = HS_W + HC_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [SLOT_W-1:0] wr_slot,
	input  logic [COL_W-1:0]  wr_col,
	input  logic [E_W-1:0]    wr_data,
	input  logic              job_empty,
	output logic              job_pop,
	input  logic [COL_W-1:0]  job_col,
	input  logic [ROW_W-1:0]  job_row,
	input  logic [SLOT_W-1:0] job_slot,
	input  logic [R_W-1:0]    job_r,
	input  logic              job_clr,
	output logic              reading,
	input  logic              pop,
	output logic              empty,
	output out_beat_t         result
);

	localparam int DEPTH = RING * (1 << COL_W);
	localparam int VS_W  = $clog2(RING * RING * 255 + 1);
	localparam int VC_W  = $clog2(RING * RING + 1);
	localparam int DW    = VS_W + 8;
	localparam int DC_W  = $clog2(DW);

	logic [E_W-1:0]    row_sums_q [DEPTH];
	logic [E_W-1:0]    rd_data_q;
	logic              rd_en;

	back_state_t       state_q, state_d;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SLOT_W-1:0] slot_q;
	logic [R_W-1:0]    r_q;
	logic [SLOT_W-1:0] k_q;
	logic              acc_en_q;
	logic [VS_W-1:0]   vs_q;
	logic [VC_W-1:0]   vc_q;
	logic [DW-1:0]     quo_q;
	logic [VC_W-1:0]   rem_q;
	logic [DC_W-1:0]   dcnt_q;
	logic              nz_q;
	logic [AVG_W-1:0]  held_q;
	out_beat_t         out_q;
	logic              out_valid_q;

	logic [VC_W:0]     trial;
	logic              ge;
	logic [VC_W:0]     rem_nx;
	logic [AVG_W-1:0]  avg;
	logic [COL_W-1:0]  cdiff;
	logic [ROW_W-1:0]  rdiff;
	logic              out_free;

	// divider step, one quotient bit per cycle
	always_comb begin
		trial  = {rem_q, quo_q[DW-1]};
		ge     = (trial >= {1'b0, vc_q});
		rem_nx = ge ? (trial - {1'b0, vc_q}) : trial;
	end

	// result fields
	always_comb begin
		avg      = nz_q ? quo_q[AVG_W-1:0] : held_q;
		cdiff    = col_q - COL_W'(r_q);
		rdiff    = row_q - ROW_W'(r_q);
		out_free = !out_valid_q || pop;
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		rd_en   = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!job_empty) begin
					job_pop = 1'b1;
					state_d = B_READ;
				end
			end
			B_READ: begin
				rd_en = 1'b1;
				if (k_q == SLOT_W'({r_q, 1'b0})) begin
					state_d = B_DRAIN;
				end
			end
			B_DRAIN: begin
				state_d = B_LOAD;
			end
			B_LOAD: begin
				state_d = (vc_q == '0) ? B_OUT : B_DIV;
			end
			B_DIV: begin
				if (dcnt_q == DC_W'(DW - 1)) begin
					state_d = B_OUT;
				end
			end
			B_OUT: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	assign reading = (state_q == B_READ);
	assign empty   = !out_valid_q;
	assign result  = out_q;

	// row sum store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_sums_q[{wr_slot, wr_col}] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= row_sums_q[{slot_q, col_q}];
		end
	end

	// control state, held average and result register flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			acc_en_q    <= 1'b0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			acc_en_q <= rd_en;
			if (job_pop && job_clr) begin
				held_q <= '0;
			end else if (state_q == B_OUT && out_free) begin
				held_q <= avg;
			end
			if (state_q == B_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// job datapath
	always_ff @(posedge clk) begin
		if (job_pop) begin
			col_q  <= job_col;
			row_q  <= job_row;
			slot_q <= job_slot;
			r_q    <= job_r;
			k_q    <= '0;
			vs_q   <= '0;
			vc_q   <= '0;
		end else if (acc_en_q) begin
			vs_q <= vs_q + VS_W'(rd_data_q[E_W-1:HC_W]);
			vc_q <= vc_q + VC_W'(rd_data_q[HC_W-1:0]);
		end
		if (rd_en) begin
			slot_q <= (slot_q == '0) ? SLOT_W'(RING - 1) : slot_q - 1'b1;
			k_q    <= k_q + 1'b1;
		end
		if (state_q == B_LOAD) begin
			quo_q  <= {vs_q, 8'b0};
			rem_q  <= '0;
			dcnt_q <= '0;
			nz_q   <= (vc_q != '0);
		end else if (state_q == B_DIV) begin
			quo_q  <= {quo_q[DW-2:0], ge};
			rem_q  <= rem_nx[VC_W-1:0];
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (state_q == B_OUT && out_free) begin
			out_q.average       <= avg;
			out_q.centre_column <= OUT_COL_W'(cdiff);
			out_q.centre_row    <= rdiff;
		end
	end

endmodule

// ===== rtl/core/masked_box_average_filter.sv =====
// top level of the masked box average filter
//
//   channel   direction  handshake             payload
//   item      in         push / full           in_beat_t
//   result    out        empty / pop           out_beat_t
//   config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// the front takes a pixel through its idle, sum and write states; a pixel that writes the row
// sum store also waits until the job queue is empty and the back has finished its store reads.
// a job takes the back through idle (pop), 2*r+1 store reads, the drain and load states, VS_W+8
// divider steps (26 at the default radius limit, none for an empty window) and the out state,
// which loads the result register once it is free; the single read port and the divider pace it.
// reset clears position, held average, queues and state; the row sum store is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module masked_box_average_filter import mbaf_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_RADIUS = 15
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  in_beat_t   item,
	output logic       empty,
	input  logic       pop,
	output out_beat_t  result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [11:0] cfg_data
);

	localparam int RING   = 2 * MAX_RADIUS + 1;
	localparam int SLOT_W = $clog2(RING);
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int R_W    = $clog2(MAX_RADIUS + 1);
	localparam int HS_W   = $clog2(RING * 255 + 1);
	localparam int HC_W   = $clog2(RING + 1);
	localparam int E_W    = HS_W + HC_W;
	localparam int JOB_W  = COL_W + ROW_W + SLOT_W + R_W + 1;

	cfg_t              cfg_q;
	logic              wr_en;
	logic [SLOT_W-1:0] wr_slot;
	logic [COL_W-1:0]  wr_col;
	logic [E_W-1:0]    wr_data;
	logic              job_push, job_full, job_pop, job_empty;
	logic              back_reading;
	logic [COL_W-1:0]  f_col, b_col;
	logic [ROW_W-1:0]  f_row, b_row;
	logic [SLOT_W-1:0] f_slot, b_slot;
	logic [R_W-1:0]    f_r, b_r;
	logic              f_clr, b_clr;
	logic [JOB_W-1:0]  job_in, job_out;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius       <= RADIUS_RESET;
			cfg_q.frame_width  <= WIDTH_RESET;
			cfg_q.frame_height <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RADIUS:       cfg_q.radius       <= cfg_data[3:0];
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data;
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data;
				default: ;
			endcase
		end
	end

	// front
	mbaf_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_RADIUS (MAX_RADIUS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.item         (item),
		.cfg          (cfg_q),
		.wr_en        (wr_en),
		.wr_slot      (wr_slot),
		.wr_col       (wr_col),
		.wr_data      (wr_data),
		.job_push     (job_push),
		.job_full     (job_full),
		.job_empty    (job_empty),
		.back_reading (back_reading),
		.job_col      (f_col),
		.job_row      (f_row),
		.job_slot     (f_slot),
		.job_r        (f_r),
		.job_clr      (f_clr)
	);

	// job queue
	assign job_in = {f_col, f_row, f_slot, f_r, f_clr};
	assign {b_col, b_row, b_slot, b_r, b_clr} = job_out;

	mbaf_fifo #(
		.W     (JOB_W),
		.DEPTH (JOB_DEPTH)
	) u_jobs (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.data_in  (job_in),
		.full     (job_full),
		.pop      (job_pop),
		.data_out (job_out),
		.empty    (job_empty)
	);

	// back
	mbaf_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_RADIUS (MAX_RADIUS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_slot   (wr_slot),
		.wr_col    (wr_col),
		.wr_data   (wr_data),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.job_col   (b_col),
		.job_row   (b_row),
		.job_slot  (b_slot),
		.job_r     (b_r),
		.job_clr   (b_clr),
		.reading   (back_reading),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

	// internal checks
	`ASSERT_CLK(a_job_no_overflow, !(job_push && job_full), "job pushed into a full queue")
	`ASSERT_CLK(a_job_no_underflow, !(job_pop && job_empty), "job popped from an empty queue")
	`ASSERT_NEXT(a_front_busy, push && !full, full, "front not busy after taking a pixel")

endmodule
